// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define ASSERT_NEXT(lbl, cond, nxt, msg) \
    `ASSERT_CLK(lbl, (cond) |=> (nxt), msg)

`endif

// File: hw/rtl/rbad_pkg.sv
package rbad_pkg;

    localparam int DEF_MAX_DST_WIDTH = 4096;
    localparam int DEF_MAX_SRC_DIM   = 16384;

    localparam int SUM_W   = 36;
    localparam int COUNT_W = 29;
    localparam int ENTRY_W = 3 * SUM_W + COUNT_W;

    // Register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } rbad_reg_t;

    typedef enum logic [2:0] {
        ST_PREP_LOAD,
        ST_PREP_RUN,
        ST_INIT,
        ST_IDLE,
        ST_RMW,
        ST_DIV
    } rbad_state_t;

    // Request to the averaging divider
    typedef struct packed {
        logic               start;
        logic [SUM_W-1:0]   red_sum;
        logic [SUM_W-1:0]   green_sum;
        logic [SUM_W-1:0]   blue_sum;
        logic [COUNT_W-1:0] count;
    } rbad_avg_req_t;

    // Status and results of the averaging divider
    typedef struct packed {
        logic       busy;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rbad_avg_res_t;

endpackage

// File: hw/rtl/rgb_box_average_downscaler.sv
// RGB box-average downscaler.
// Source pixels enter on s_axis in raster order (tdata = red, green, blue).
// Each output cell's pixels are summed per channel in a column accumulator
// memory (one entry per output column); when the cell's bottom-right pixel
// arrives the truncated averages leave on m_axis with the cell's column and
// row, and tlast marks the last cell of the image.
// Size registers are written over the APB port; any write restarts the image.
// Pixels are taken one at a time: s_axis_tready stays low while a pixel's
// read-modify-write of the accumulator memory (whose read is registered)
// runs and, for a pixel that closes a cell, while the bit-serial divider
// works and until its result is loaded into the output register.
// After reset and after every register write the block computes the cell
// boundary steps with a shared serial divider and holds s_axis_tready low
// while it does so.
// The output register decouples the sides: new pixels are taken while a
// result waits; only a second result waits for m_axis_tready.
module rgb_box_average_downscaler #(
    parameter int MAX_DST_WIDTH = rbad_pkg::DEF_MAX_DST_WIDTH,
    parameter int MAX_SRC_DIM   = rbad_pkg::DEF_MAX_SRC_DIM
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // red_out, green_out, blue_out, out_col, out_row
    output logic        m_axis_tlast,   // image_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DIM_W   = $clog2(MAX_SRC_DIM + 1);
    localparam int AW      = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int PCNT_W  = $clog2(DIM_W + 1);
    localparam int SUM_W   = rbad_pkg::SUM_W;
    localparam int COUNT_W = rbad_pkg::COUNT_W;
    localparam int ENTRY_W = rbad_pkg::ENTRY_W;

    // ---------------- configuration ----------------
    logic [14:0] src_width_reg, src_height_reg, dst_height_reg;
    logic [12:0] dst_width_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 15'd1;
            src_height_reg <= 15'd1;
            dst_width_reg  <= 13'd1;
            dst_height_reg <= 15'd1;
        end
        else if (cfg_wr)
        begin
            case (rbad_pkg::rbad_reg_t'(paddr[3:2]))
                rbad_pkg::REG_SRC_WIDTH:  src_width_reg  <= pwdata[14:0];
                rbad_pkg::REG_SRC_HEIGHT: src_height_reg <= pwdata[14:0];
                rbad_pkg::REG_DST_WIDTH:  dst_width_reg  <= pwdata[12:0];
                rbad_pkg::REG_DST_HEIGHT: dst_height_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (rbad_pkg::rbad_reg_t'(paddr[3:2]))
            rbad_pkg::REG_SRC_WIDTH:  prdata = 32'(src_width_reg);
            rbad_pkg::REG_SRC_HEIGHT: prdata = 32'(src_height_reg);
            rbad_pkg::REG_DST_WIDTH:  prdata = 32'(dst_width_reg);
            rbad_pkg::REG_DST_HEIGHT: prdata = 32'(dst_height_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    // Effective sizes: zero acts as one, then clamps
    logic [DIM_W-1:0] eff_w, eff_h, eff_dw, eff_dh;
    always_comb
    begin
        logic [31:0] ew, eh, edw, edh;
        ew  = (src_width_reg == 15'd0) ? 32'd1 :
              (32'(src_width_reg) > MAX_SRC_DIM) ? 32'(MAX_SRC_DIM) : 32'(src_width_reg);
        eh  = (src_height_reg == 15'd0) ? 32'd1 :
              (32'(src_height_reg) > MAX_SRC_DIM) ? 32'(MAX_SRC_DIM) : 32'(src_height_reg);
        edw = (dst_width_reg == 13'd0) ? 32'd1 :
              (32'(dst_width_reg) > MAX_DST_WIDTH) ? 32'(MAX_DST_WIDTH) : 32'(dst_width_reg);
        if (edw > ew)
        begin
            edw = ew;
        end
        edh = (dst_height_reg == 15'd0) ? 32'd1 :
              (32'(dst_height_reg) > eh) ? eh : 32'(dst_height_reg);
        eff_w  = DIM_W'(ew);
        eff_h  = DIM_W'(eh);
        eff_dw = DIM_W'(edw);
        eff_dh = DIM_W'(edh);
    end

    // ---------------- state machine ----------------
    rbad_pkg::rbad_state_t state_reg, state_next;
    logic              phase_reg;
    logic [PCNT_W-1:0] pcnt_reg;
    logic              prep_last;
    logic              in_acc;
    logic              last_reg;
    logic              out_valid_reg;
    logic              out_load;
    logic              mem_we;
    rbad_pkg::rbad_avg_req_t avg_req;
    rbad_pkg::rbad_avg_res_t avg_res;

    assign prep_last = (pcnt_reg == PCNT_W'(DIM_W - 1));
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rbad_pkg::ST_PREP_LOAD: state_next = rbad_pkg::ST_PREP_RUN;
            rbad_pkg::ST_PREP_RUN:
                if (prep_last)
                begin
                    state_next = phase_reg ? rbad_pkg::ST_INIT : rbad_pkg::ST_PREP_LOAD;
                end
            rbad_pkg::ST_INIT:      state_next = rbad_pkg::ST_IDLE;
            rbad_pkg::ST_IDLE:
                if (in_acc)
                begin
                    state_next = rbad_pkg::ST_RMW;
                end
            rbad_pkg::ST_RMW:
                state_next = last_reg ? rbad_pkg::ST_DIV : rbad_pkg::ST_IDLE;
            rbad_pkg::ST_DIV:
                if (out_load)
                begin
                    state_next = rbad_pkg::ST_IDLE;
                end
            default:                state_next = rbad_pkg::ST_PREP_LOAD;
        endcase
        if (cfg_wr)
        begin
            state_next = rbad_pkg::ST_PREP_LOAD;
        end
    end

    always_comb
    begin
        s_axis_tready = (state_reg == rbad_pkg::ST_IDLE);
        mem_we        = (state_reg == rbad_pkg::ST_RMW);
        out_load      = (state_reg == rbad_pkg::ST_DIV) && !avg_res.busy &&
                        (!out_valid_reg || m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbad_pkg::ST_PREP_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- boundary step divider ----------------
    logic [DIM_W-1:0] prep_rem_reg, prep_quo_reg, prep_dvd_reg;
    logic [DIM_W-1:0] prep_divisor, rem_step, quo_step;
    logic [DIM_W:0]   trial;
    logic             trial_ge;
    logic [DIM_W-1:0] w_div_reg, w_mod_reg, h_div_reg, h_mod_reg;

    assign prep_divisor = phase_reg ? eff_dh : eff_dw;
    assign trial        = {prep_rem_reg, prep_dvd_reg[DIM_W-1]};
    assign trial_ge     = trial >= {1'b0, prep_divisor};
    assign rem_step     = trial_ge ? DIM_W'(trial - {1'b0, prep_divisor}) : DIM_W'(trial);
    assign quo_step     = DIM_W'({prep_quo_reg, trial_ge});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            pcnt_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            phase_reg <= 1'b0;
        end
        else if (state_reg == rbad_pkg::ST_PREP_LOAD)
        begin
            pcnt_reg <= '0;
        end
        else if (state_reg == rbad_pkg::ST_PREP_RUN)
        begin
            pcnt_reg <= pcnt_reg + PCNT_W'(1);
            if (prep_last)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rbad_pkg::ST_PREP_LOAD)
        begin
            prep_rem_reg <= '0;
            prep_quo_reg <= '0;
            prep_dvd_reg <= phase_reg ? eff_h : eff_w;
        end
        else if (state_reg == rbad_pkg::ST_PREP_RUN)
        begin
            prep_rem_reg <= rem_step;
            prep_quo_reg <= quo_step;
            prep_dvd_reg <= DIM_W'({prep_dvd_reg, 1'b0});
            if (prep_last && !phase_reg)
            begin
                w_div_reg <= quo_step;
                w_mod_reg <= rem_step;
            end
            if (prep_last && phase_reg)
            begin
                h_div_reg <= quo_step;
                h_mod_reg <= rem_step;
            end
        end
    end

    // ---------------- source position and cell tracking ----------------
    logic [DIM_W-1:0] src_col_reg, src_row_reg, src_col_next, src_row_next;
    logic [AW-1:0]    cell_col_reg, cell_col_next;
    logic [DIM_W-1:0] cell_row_reg, cell_row_next;
    logic [DIM_W-1:0] col_start_reg, col_end_reg, col_rem_reg;
    logic [DIM_W-1:0] col_start_next, col_end_next, col_rem_next;
    logic [DIM_W-1:0] row_start_reg, row_end_reg, row_rem_reg;
    logic [DIM_W-1:0] row_start_next, row_end_next, row_rem_next;
    logic             px_first, px_last, px_done;

    assign px_first = (src_row_reg == row_start_reg) && (src_col_reg == col_start_reg);
    assign px_last  = (32'(src_col_reg) + 32'd1 == 32'(col_end_reg)) &&
                      (32'(src_row_reg) + 32'd1 == 32'(row_end_reg));
    assign px_done  = (32'(cell_col_reg) + 32'd1 == 32'(eff_dw)) &&
                      (32'(cell_row_reg) + 32'd1 == 32'(eff_dh));

    always_comb
    begin
        logic [DIM_W:0] csum, rsum;
        logic           ccarry, rcarry;
        src_col_next   = src_col_reg;
        src_row_next   = src_row_reg;
        cell_col_next  = cell_col_reg;
        cell_row_next  = cell_row_reg;
        col_start_next = col_start_reg;
        col_end_next   = col_end_reg;
        col_rem_next   = col_rem_reg;
        row_start_next = row_start_reg;
        row_end_next   = row_end_reg;
        row_rem_next   = row_rem_reg;
        csum   = {1'b0, col_rem_reg} + {1'b0, w_mod_reg};
        ccarry = csum >= {1'b0, eff_dw};
        rsum   = {1'b0, row_rem_reg} + {1'b0, h_mod_reg};
        rcarry = rsum >= {1'b0, eff_dh};
        if (state_reg == rbad_pkg::ST_INIT)
        begin
            src_col_next   = '0;
            src_row_next   = '0;
            cell_col_next  = '0;
            cell_row_next  = '0;
            col_start_next = '0;
            col_end_next   = w_div_reg;
            col_rem_next   = w_mod_reg;
            row_start_next = '0;
            row_end_next   = h_div_reg;
            row_rem_next   = h_mod_reg;
        end
        else if (in_acc)
        begin
            src_col_next = src_col_reg + DIM_W'(1);
            // next cell column: end += w/dw with remainder carry
            if (src_col_next == col_end_reg && 32'(cell_col_reg) + 32'd1 < 32'(eff_dw))
            begin
                cell_col_next  = cell_col_reg + AW'(1);
                col_start_next = col_end_reg;
                col_end_next   = col_end_reg + w_div_reg + DIM_W'(ccarry);
                col_rem_next   = ccarry ? DIM_W'(csum - {1'b0, eff_dw}) : DIM_W'(csum);
            end
            // end of source row
            if (src_col_next >= eff_w)
            begin
                src_col_next   = '0;
                cell_col_next  = '0;
                col_start_next = '0;
                col_end_next   = w_div_reg;
                col_rem_next   = w_mod_reg;
                src_row_next   = src_row_reg + DIM_W'(1);
                if (src_row_next == row_end_reg &&
                    32'(cell_row_reg) + 32'd1 < 32'(eff_dh))
                begin
                    cell_row_next  = cell_row_reg + DIM_W'(1);
                    row_start_next = row_end_reg;
                    row_end_next   = row_end_reg + h_div_reg + DIM_W'(rcarry);
                    row_rem_next   = rcarry ? DIM_W'(rsum - {1'b0, eff_dh}) : DIM_W'(rsum);
                end
                if (src_row_next >= eff_h)
                begin
                    src_row_next   = '0;
                    cell_row_next  = '0;
                    row_start_next = '0;
                    row_end_next   = h_div_reg;
                    row_rem_next   = h_mod_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            cell_col_reg  <= '0;
            cell_row_reg  <= '0;
            col_start_reg <= '0;
            col_end_reg   <= '0;
            col_rem_reg   <= '0;
            row_start_reg <= '0;
            row_end_reg   <= '0;
            row_rem_reg   <= '0;
        end
        else
        begin
            src_col_reg   <= src_col_next;
            src_row_reg   <= src_row_next;
            cell_col_reg  <= cell_col_next;
            cell_row_reg  <= cell_row_next;
            col_start_reg <= col_start_next;
            col_end_reg   <= col_end_next;
            col_rem_reg   <= col_rem_next;
            row_start_reg <= row_start_next;
            row_end_reg   <= row_end_next;
            row_rem_reg   <= row_rem_next;
        end
    end

    // ---------------- accumulator memory ----------------
    logic [ENTRY_W-1:0] acc_mem [MAX_DST_WIDTH];
    logic [ENTRY_W-1:0] rd_data_reg, wr_data;
    logic [AW-1:0]      addr_reg;
    logic [23:0]        pix_reg;
    logic               first_reg, done_reg;
    logic [11:0]        col_tag_reg;
    logic [13:0]        row_tag_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rd_data_reg <= acc_mem[cell_col_reg];
            addr_reg    <= cell_col_reg;
            pix_reg     <= s_axis_tdata;
            first_reg   <= px_first;
            last_reg    <= px_last;
            done_reg    <= px_done;
            col_tag_reg <= 12'(cell_col_reg);
            row_tag_reg <= 14'(cell_row_reg);
        end
        if (mem_we)
        begin
            acc_mem[addr_reg] <= wr_data;
        end
    end

    // Read-modify-write: first pixel of a cell overwrites the entry
    always_comb
    begin
        logic [SUM_W-1:0]   r_sum, g_sum, b_sum;
        logic [COUNT_W-1:0] cnt;
        if (first_reg)
        begin
            r_sum = SUM_W'(pix_reg[7:0]);
            g_sum = SUM_W'(pix_reg[15:8]);
            b_sum = SUM_W'(pix_reg[23:16]);
            cnt   = COUNT_W'(1);
        end
        else
        begin
            r_sum = rd_data_reg[SUM_W-1:0] + SUM_W'(pix_reg[7:0]);
            g_sum = rd_data_reg[2*SUM_W-1:SUM_W] + SUM_W'(pix_reg[15:8]);
            b_sum = rd_data_reg[3*SUM_W-1:2*SUM_W] + SUM_W'(pix_reg[23:16]);
            cnt   = rd_data_reg[ENTRY_W-1:3*SUM_W] + COUNT_W'(1);
        end
        wr_data           = {cnt, b_sum, g_sum, r_sum};
        avg_req.start     = mem_we && last_reg;
        avg_req.red_sum   = r_sum;
        avg_req.green_sum = g_sum;
        avg_req.blue_sum  = b_sum;
        avg_req.count     = cnt;
    end

    rbad_avg u_avg (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (avg_req),
        .res   (avg_res)
    );

    // ---------------- output register ----------------
    logic [49:0] out_data_reg;
    logic        out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {row_tag_reg, col_tag_reg, avg_res.blue, avg_res.green,
                             avg_res.red};
            out_last_reg <= done_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: hw/rtl/rbad_avg.sv
// Three-channel sum/count divider, one quotient bit per cycle.
// The average of 8-bit samples is below 256, so eight steps suffice.
module rbad_avg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rbad_pkg::rbad_avg_req_t req,
    output rbad_pkg::rbad_avg_res_t res
);

    logic [2:0][rbad_pkg::SUM_W-1:0] rem_reg;
    logic [2:0][rbad_pkg::SUM_W-1:0] rem_next;
    logic [2:0][7:0]                 quo_reg;
    logic [2:0][7:0]                 quo_next;
    logic [rbad_pkg::SUM_W-1:0]      dsr_reg;
    logic [2:0]                      cnt_reg;
    logic                            busy_reg;

    // One restoring step on each channel
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (rem_reg[i] >= dsr_reg)
            begin
                rem_next[i] = rem_reg[i] - dsr_reg;
                quo_next[i] = {quo_reg[i][6:0], 1'b1};
            end
            else
            begin
                rem_next[i] = rem_reg[i];
                quo_next[i] = {quo_reg[i][6:0], 1'b0};
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 3'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg[0] <= req.red_sum;
            rem_reg[1] <= req.green_sum;
            rem_reg[2] <= req.blue_sum;
            dsr_reg    <= {req.count, 7'b0};
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dsr_reg <= dsr_reg >> 1;
        end
    end

    assign res.busy  = busy_reg;
    assign res.red   = quo_reg[0];
    assign res.green = quo_reg[1];
    assign res.blue  = quo_reg[2];

endmodule

// File: hw/rtl/rbad_checker.sv
`include "assert_macros.svh"

// Port-level checks for the downscaler.
module rbad_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite
);

    // Stalled output item is held
    `ASSERT_NEXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output dropped while stalled")
    `ASSERT_NEXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output changed while stalled")

    // One item in flight: the accumulator update blocks the next pixel
    `ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "pixel taken during accumulator update")

    // A register write restarts the image and recomputes cell bounds
    `ASSERT_NEXT(a_cfg_restart, psel && penable && pwrite, !s_axis_tready, "pixel taken right after register write")

endmodule

bind rgb_box_average_downscaler rbad_checker u_rbad_checker (.*);

// File: sim/tb_rgb_box_average_downscaler.sv
`timescale 1ns / 1ps

module tb_rgb_box_average_downscaler;

    // One finished output cell
    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] col;
        logic [13:0] row;
        logic        done;
    } cell_avg_t;

    // Predicts the cell averages and checks them in order
    class cell_scoreboard;
        int unsigned reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
        int unsigned w, h, dw, dh;
        logic [35:0] red_acc[4096];
        logic [35:0] green_acc[4096];
        logic [35:0] blue_acc[4096];
        logic [28:0] pix_count[4096];
        int unsigned px_col, px_row, cell_x, cell_y, x_end, y_end;
        cell_avg_t   cells_due[$];
        int          errors;
        int          cells_seen;
        int          images_done;

        function new();
            reg_src_w = 1;
            reg_src_h = 1;
            reg_dst_w = 1;
            reg_dst_h = 1;
            errors = 0;
            cells_seen = 0;
            images_done = 0;
            restart();
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        function int unsigned edge_at(int unsigned idx, int unsigned src, int unsigned dst);
            longint unsigned prod;
            prod = longint'(idx) * src;
            return int'(prod / dst);
        endfunction

        function void restart();
            w  = clamp_size(reg_src_w, 16384);
            h  = clamp_size(reg_src_h, 16384);
            dw = clamp_size(reg_dst_w, 4096);
            if (dw > w)
                dw = w;
            dh = clamp_size(reg_dst_h, h);
            px_col = 0;
            px_row = 0;
            cell_x = 0;
            cell_y = 0;
            x_end  = edge_at(1, w, dw);
            y_end  = edge_at(1, h, dh);
        endfunction

        function void write_reg(rbad_pkg::rbad_reg_t idx, int unsigned v);
            case (idx)
                rbad_pkg::REG_SRC_WIDTH:  reg_src_w = v & 32'h7FFF;
                rbad_pkg::REG_SRC_HEIGHT: reg_src_h = v & 32'h7FFF;
                rbad_pkg::REG_DST_WIDTH:  reg_dst_w = v & 32'h1FFF;
                rbad_pkg::REG_DST_HEIGHT: reg_dst_h = v & 32'h7FFF;
                default: ;
            endcase
            restart();
        endfunction

        // Accumulate one source pixel; queue a cell if it closes one
        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned k;
            logic [35:0] c;
            cell_avg_t   e;
            k = cell_x % 4096;
            if (px_row == edge_at(cell_y, h, dh) && px_col == edge_at(cell_x, w, dw))
            begin
                red_acc[k]   = 36'(r);
                green_acc[k] = 36'(g);
                blue_acc[k]  = 36'(b);
                pix_count[k] = 29'd1;
            end
            else
            begin
                red_acc[k]   = red_acc[k] + 36'(r);
                green_acc[k] = green_acc[k] + 36'(g);
                blue_acc[k]  = blue_acc[k] + 36'(b);
                pix_count[k] = pix_count[k] + 29'd1;
            end
            if (px_col + 1 == x_end && px_row + 1 == y_end)
            begin
                c = (pix_count[k] == 0) ? 36'd1 : 36'(pix_count[k]);
                e.red   = 8'(red_acc[k] / c);
                e.green = 8'(green_acc[k] / c);
                e.blue  = 8'(blue_acc[k] / c);
                e.col   = 12'(cell_x);
                e.row   = 14'(cell_y);
                e.done  = (cell_x + 1 == dw && cell_y + 1 == dh);
                cells_due.push_back(e);
            end
            // advance the raster position
            px_col++;
            if (px_col == x_end && cell_x + 1 < dw)
            begin
                cell_x++;
                x_end = edge_at(cell_x + 1, w, dw);
            end
            if (px_col >= w)
            begin
                px_col = 0;
                cell_x = 0;
                x_end  = edge_at(1, w, dw);
                px_row++;
                if (px_row == y_end && cell_y + 1 < dh)
                begin
                    cell_y++;
                    y_end = edge_at(cell_y + 1, h, dh);
                end
                if (px_row >= h)
                begin
                    px_row = 0;
                    cell_y = 0;
                    y_end  = edge_at(1, h, dh);
                end
            end
        endfunction

        function void check_cell(logic [55:0] d, logic last);
            cell_avg_t e;
            if (cells_due.size() == 0)
            begin
                $error("output cell with none expected: tdata=%h tlast=%b", d, last);
                errors++;
                return;
            end
            e = cells_due.pop_front();
            cells_seen++;
            if (last)
                images_done++;
            if (d[7:0] !== e.red)
            begin
                $error("red_out: expected %0d, got %0d", e.red, d[7:0]);
                errors++;
            end
            if (d[15:8] !== e.green)
            begin
                $error("green_out: expected %0d, got %0d", e.green, d[15:8]);
                errors++;
            end
            if (d[23:16] !== e.blue)
            begin
                $error("blue_out: expected %0d, got %0d", e.blue, d[23:16]);
                errors++;
            end
            if (d[35:24] !== e.col)
            begin
                $error("out_col: expected %0d, got %0d", e.col, d[35:24]);
                errors++;
            end
            if (d[49:36] !== e.row)
            begin
                $error("out_row: expected %0d, got %0d", e.row, d[49:36]);
                errors++;
            end
            if (last !== e.done)
            begin
                $error("image_done: expected %0b, got %0b", e.done, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // red_in, green_in, blue_in
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // red_out, green_out, blue_out, out_col, out_row
    logic        m_axis_tlast;   // image_done
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cell_scoreboard sb;
    int pixels_sent;
    int burst_left;
    int hold_request;
    int phases;

    rgb_box_average_downscaler uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    // Output side: check cells, stall in changing modes, long hold on request
    initial
    begin : receiver
        int cyc;
        int mode;
        int hold;
        cyc = 0;
        mode = 0;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_cell(m_axis_tdata, m_axis_tlast);
            @(negedge clk);
            cyc++;
            if (cyc % 150 == 0)
                mode = $urandom_range(0, 3);
            if (hold_request > 0)
            begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= (cyc % 5 != 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Caps a phase's pixel count so the run stays near its item budget
    function automatic int budget(int want);
        int left;
        left = 760 - pixels_sent;
        if (left < 0)
            left = 0;
        return (want > left) ? left : want;
    endfunction

    task automatic apb_write(rbad_pkg::rbad_reg_t idx, int unsigned v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(idx, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh);
        apb_write(rbad_pkg::REG_SRC_WIDTH, sw);
        apb_write(rbad_pkg::REG_SRC_HEIGHT, sh);
        apb_write(rbad_pkg::REG_DST_WIDTH, dw);
        apb_write(rbad_pkg::REG_DST_HEIGHT, dh);
        phases++;
    endtask

    // Offer one pixel; bursts of random length with random gaps in between
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_pixel(r, g, b);
        pixels_sent++;
        burst_left--;
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    // Drain all cells, then let an in-flight pixel settle
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.cells_due.size() != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    initial
    begin
        int unsigned sw, sh, dw, dh;
        int n;
        sb = new();
        pixels_sent = 0;
        burst_left = 0;
        hold_request = 0;
        phases = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset sizes: every pixel is a whole image
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        drain();

        // 4x2 into 2x1 with extreme channel values
        set_sizes(4, 2, 2, 1);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd1);
        send_pixel(8'd1, 8'd255, 8'd254);
        send_pixel(8'd255, 8'd0, 8'd128);
        send_pixel(8'd254, 8'd1, 8'd127);
        send_pixel(8'd3, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd254, 8'd255);
        drain();

        // Destination larger than source
        set_sizes(2, 2, 5, 7);
        send_random(4);
        drain();

        // Zero sizes act as one
        set_sizes(0, 0, 0, 0);
        send_random(2);
        drain();

        // Oversized source and destination, partial image
        set_sizes(20000, 30000, 5000, 20000);
        send_random(8);
        drain();

        // Long output hold while pixels keep coming: input must stall
        set_sizes(4, 4, 2, 2);
        hold_request = 400;
        send_random(64);
        drain();

        // Random phases: mostly whole images at small sizes
        while (pixels_sent < 740)
        begin
            n = $urandom_range(0, 19);
            if (n == 0)
            begin
                sw = $urandom_range(0, 1) ? 16384 : 32767;
                sh = $urandom_range(1, 16384);
                dw = $urandom_range(0, 1) ? 4096 : 8191;
                dh = $urandom_range(1, 32767);
                set_sizes(sw, sh, dw, dh);
                send_random(budget($urandom_range(10, 40)));
            end
            else
            begin
                sw = $urandom_range(1, 12);
                sh = $urandom_range(1, 8);
                dw = $urandom_range(0, sw + 2);
                dh = $urandom_range(0, sh + 2);
                set_sizes(sw, sh, dw, dh);
                if (n == 1)
                    send_random(budget($urandom_range(1, sw * sh)));
                else
                    send_random(budget(sw * sh * $urandom_range(1, 3)));
                if (n == 2)
                begin
                    // long output hold while pixels keep coming
                    hold_request = 400;
                    send_random(budget(sw * sh * 4));
                end
            end
            drain();
        end

        if (sb.cells_due.size() != 0)
        begin
            $error("%0d expected cells never arrived", sb.cells_due.size());
            sb.errors++;
        end
        $display("Covered %0d pixels over %0d size settings, %0d cells checked, %0d images.",
                 pixels_sent, phases, sb.cells_seen, sb.images_done);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
